### rtl/core/ifq_pkg.sv
// shared types and constants of the indication flow queue
package ifq_pkg;

    // queue geometry
    localparam int QDEPTH = 16;
    localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNTW   = $clog2(QDEPTH + 1);

    // configuration port
    localparam int CFG_W  = 16;
    localparam logic [0:0] REG_TEMP_HANDLE = 1'd0;
    localparam logic [0:0] REG_HR_HANDLE   = 1'd1;
    localparam logic [15:0] TEMP_HANDLE_RST = 16'd0;
    localparam logic [15:0] HR_HANDLE_RST   = 16'd1;

    // function codes of an input word
    localparam logic [2:0] FN_SEND    = 3'd0;
    localparam logic [2:0] FN_STATUS  = 3'd1;
    localparam logic [2:0] FN_TIMEOUT = 3'd2;
    localparam logic [2:0] FN_OPENED  = 3'd3;
    localparam logic [2:0] FN_CLOSED  = 3'd4;
    localparam logic [2:0] FN_TICK    = 3'd5;

    // outcome codes of a result word
    localparam logic [2:0] OC_SENT   = 3'd0;
    localparam logic [2:0] OC_QUEUED = 3'd1;
    localparam logic [2:0] OC_FULL   = 3'd2;
    localparam logic [2:0] OC_DENIED = 3'd3;
    localparam logic [2:0] OC_NONE   = 3'd4;

    // status flag and client configuration values
    localparam logic [7:0] SF_CONFIG  = 8'h01;
    localparam logic [7:0] SF_CONFIRM = 8'h02;
    localparam logic [7:0] CC_ENABLE  = 8'h02;
    localparam logic [7:0] CC_DISABLE = 8'h00;

    // longest payload in bytes
    localparam logic [2:0] MAX_LEN = 3'd5;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] char_handle;
        logic [39:0] payload;
        logic [2:0]  payload_length;
        logic [7:0]  evt_flags;
        logic [7:0]  client_config;
        logic [7:0]  link_id;
    } item_t;

    typedef struct packed {
        logic        send_valid;
        logic [15:0] send_handle;
        logic [7:0]  send_link;
        logic [2:0]  send_length;
        logic [39:0] send_payload;
        logic [2:0]  outcome;
        logic [4:0]  queue_count;
        logic        in_flight;
    } result_t;

    typedef struct packed {
        logic [15:0] handle;
        logic [2:0]  length;
        logic [39:0] payload;
    } qentry_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_DENY,
        ACT_SEND_NEW,
        ACT_QUEUE,
        ACT_DROP_FULL,
        ACT_SEND_HEAD
    } act_t;

    typedef struct packed {
        logic load;
        logic exec;
        act_t act;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       allowed;
        logic       awaiting;
        logic       full;
        logic       tick_ok;
    } dp_status_t;

endpackage

### rtl/core/indication_flow_queue.sv
// top level of the indication flow queue
//
// Each accepted word is taken by start while busy is low; busy is then high
// for the execute state that follows, and the result word shows on result
// with done high in the cycle after that, for one cycle only. A new word can
// be taken only once busy is low again; the execute state is set by the
// registered read of the queue memory, whose head entry is fetched at the
// accepting edge. The receiver has no way to stall results. Configuration
// writes on cfg_en/cfg_index/cfg_data take effect at once and belong to idle
// periods. Queue storage is not cleared by reset; only written entries are
// ever issued.
module indication_flow_queue
    import ifq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  item_t            item,
    output logic             done,
    output result_t          result,
    input  logic             cfg_en,
    input  logic [0:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencing
    ifq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .status(status),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // flags, queue and result
    ifq_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .item     (item),
        .cfg_en   (cfg_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .result   (result)
    );

endmodule

### rtl/core/ifq_ram.sv
// generic single write port ram with registered read
module ifq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/ifq_ctrl.sv
// controller: sequences each word and decides what the datapath does with it
module ifq_ctrl
    import ifq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd,
    output logic       busy,
    output logic       done
);

    state_t state_reg, state_next;
    logic   done_reg, done_next;
    act_t   act;

    // state and strobe registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        act        = ACT_NONE;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
                case (status.func)
                    FN_SEND:
                    begin
                        if (!status.allowed)
                            act = ACT_DENY;
                        else if (!status.awaiting)
                            act = ACT_SEND_NEW;
                        else if (status.full)
                            act = ACT_DROP_FULL;
                        else
                            act = ACT_QUEUE;
                    end
                    FN_TICK:
                    begin
                        if (status.tick_ok)
                            act = ACT_SEND_HEAD;
                    end
                    default:
                    begin
                        act = ACT_NONE;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        cmd.act = act;
    end

    assign busy = (state_reg == ST_EXEC);
    assign done = done_reg;

endmodule

### rtl/core/ifq_datapath.sv
// datapath: link flags, queue storage and the result register
module ifq_datapath
    import ifq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ctrl_cmd_t        cmd,
    output dp_status_t       status,
    input  item_t            item,
    input  logic             cfg_en,
    input  logic [0:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output result_t          result
);

    // zero payload bytes at and above the length
    function automatic logic [39:0] mask_payload(input logic [39:0] data,
                                                 input logic [2:0] len);
        logic [39:0] res;
        res = '0;
        for (int i = 0; i < 5; i++)
        begin
            if (3'(i) < len)
                res[8*i +: 8] = data[8*i +: 8];
        end
        return res;
    endfunction

    item_t           item_reg;
    logic [15:0]     temp_handle_reg, temp_handle_next;
    logic [15:0]     hr_handle_reg, hr_handle_next;
    logic            link_open_reg, link_open_next;
    logic            awaiting_reg, awaiting_next;
    logic            temp_en_reg, temp_en_next;
    logic            hr_en_reg, hr_en_next;
    logic [7:0]      link_handle_reg, link_handle_next;
    logic [QAW-1:0]  head_reg, head_next;
    logic [QAW-1:0]  tail_reg, tail_next;
    logic [CNTW-1:0] count_reg, count_next;
    result_t         result_reg, result_next;

    logic            is_t, is_h;
    logic [2:0]      len_sat;
    qentry_t         new_entry;
    qentry_t         head_entry;
    logic [$bits(qentry_t)-1:0] ram_rdata;
    logic            q_we;
    logic            sending;

    // input word capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= item;
    end

    // queue storage
    ifq_ram #(
        .WIDTH($bits(qentry_t)),
        .DEPTH(QDEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (q_we),
        .waddr(tail_reg),
        .wdata(new_entry),
        .raddr(head_reg),
        .rdata(ram_rdata)
    );

    assign head_entry = qentry_t'(ram_rdata);

    // decode of the captured word
    assign is_t    = (item_reg.char_handle == temp_handle_reg);
    assign is_h    = (item_reg.char_handle == hr_handle_reg);
    assign len_sat = (item_reg.payload_length > MAX_LEN) ? MAX_LEN : item_reg.payload_length;

    always_comb
    begin
        new_entry.handle  = item_reg.char_handle;
        new_entry.length  = len_sat;
        new_entry.payload = mask_payload(item_reg.payload, len_sat);
    end

    // status to the controller
    assign status.func     = item_reg.func;
    assign status.allowed  = link_open_reg && ((is_t && temp_en_reg) || (is_h && hr_en_reg));
    assign status.awaiting = awaiting_reg;
    assign status.full     = (count_reg == CNTW'(QDEPTH));
    assign status.tick_ok  = link_open_reg && !awaiting_reg && (count_reg != '0);

    assign q_we    = cmd.exec && (cmd.act == ACT_QUEUE);
    assign sending = (cmd.act == ACT_SEND_NEW) || (cmd.act == ACT_SEND_HEAD);

    // next state of flags, queue pointers and result
    always_comb
    begin
        temp_handle_next = temp_handle_reg;
        hr_handle_next   = hr_handle_reg;
        link_open_next   = link_open_reg;
        awaiting_next    = awaiting_reg;
        temp_en_next     = temp_en_reg;
        hr_en_next       = hr_en_reg;
        link_handle_next = link_handle_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        result_next      = result_reg;

        // register writes
        if (cfg_en)
        begin
            case (cfg_index)
                REG_TEMP_HANDLE: temp_handle_next = cfg_data;
                REG_HR_HANDLE:   hr_handle_next   = cfg_data;
                default:         temp_handle_next = temp_handle_reg;
            endcase
        end

        if (cmd.exec)
        begin
            // link events and client configuration
            case (item_reg.func)
                FN_STATUS:
                begin
                    if (item_reg.evt_flags == SF_CONFIG)
                    begin
                        if (is_t && item_reg.client_config == CC_ENABLE)
                            temp_en_next = 1'b1;
                        else if (is_t && item_reg.client_config == CC_DISABLE)
                            temp_en_next = 1'b0;
                        if (is_h && item_reg.client_config == CC_ENABLE)
                            hr_en_next = 1'b1;
                        else if (is_h && item_reg.client_config == CC_DISABLE)
                            hr_en_next = 1'b0;
                    end
                    else if (item_reg.evt_flags == SF_CONFIRM)
                    begin
                        if (is_t || is_h)
                            awaiting_next = 1'b0;
                    end
                end
                FN_TIMEOUT:
                begin
                    awaiting_next = 1'b0;
                end
                FN_OPENED:
                begin
                    link_handle_next = item_reg.link_id;
                    link_open_next   = 1'b1;
                end
                FN_CLOSED:
                begin
                    link_open_next = 1'b0;
                    awaiting_next  = 1'b0;
                    temp_en_next   = 1'b0;
                    hr_en_next     = 1'b0;
                end
                default:
                begin
                    link_open_next = link_open_reg;
                end
            endcase

            // queue and in-flight actions
            case (cmd.act)
                ACT_SEND_NEW:
                begin
                    awaiting_next = 1'b1;
                end
                ACT_QUEUE:
                begin
                    tail_next  = (tail_reg == QAW'(QDEPTH - 1)) ? '0 : tail_reg + QAW'(1);
                    count_next = count_reg + CNTW'(1);
                end
                ACT_SEND_HEAD:
                begin
                    head_next     = (head_reg == QAW'(QDEPTH - 1)) ? '0 : head_reg + QAW'(1);
                    count_next    = count_reg - CNTW'(1);
                    awaiting_next = 1'b1;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase

            // result word
            result_next = '0;
            if (sending)
            begin
                result_next.send_valid = 1'b1;
                result_next.send_link  = link_handle_reg;
                if (cmd.act == ACT_SEND_HEAD)
                begin
                    result_next.send_handle  = head_entry.handle;
                    result_next.send_length  = head_entry.length;
                    result_next.send_payload = head_entry.payload;
                end
                else
                begin
                    result_next.send_handle  = new_entry.handle;
                    result_next.send_length  = new_entry.length;
                    result_next.send_payload = new_entry.payload;
                end
            end
            case (cmd.act)
                ACT_SEND_NEW:  result_next.outcome = OC_SENT;
                ACT_SEND_HEAD: result_next.outcome = OC_SENT;
                ACT_QUEUE:     result_next.outcome = OC_QUEUED;
                ACT_DROP_FULL: result_next.outcome = OC_FULL;
                ACT_DENY:      result_next.outcome = OC_DENIED;
                default:       result_next.outcome = OC_NONE;
            endcase
            result_next.queue_count = 5'(count_next);
            result_next.in_flight   = awaiting_next;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_handle_reg <= TEMP_HANDLE_RST;
            hr_handle_reg   <= HR_HANDLE_RST;
            link_open_reg   <= 1'b0;
            awaiting_reg    <= 1'b0;
            temp_en_reg     <= 1'b0;
            hr_en_reg       <= 1'b0;
            link_handle_reg <= '0;
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
        end
        else
        begin
            temp_handle_reg <= temp_handle_next;
            hr_handle_reg   <= hr_handle_next;
            link_open_reg   <= link_open_next;
            awaiting_reg    <= awaiting_next;
            temp_en_reg     <= temp_en_next;
            hr_en_reg       <= hr_en_next;
            link_handle_reg <= link_handle_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            count_reg       <= count_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;

    // queue never holds more than its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(QDEPTH))
        else $error("queue count above depth");

    // an empty queue has its pointers together
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty queue with split pointers");

    // queuing grows the count by one
    a_queue_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && cmd.act == ACT_QUEUE) |=> (count_reg == $past(count_reg) + CNTW'(1)))
        else $error("queued word not counted");

    // an issued indication is in flight in its own result
    a_send_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && (cmd.act == ACT_SEND_NEW || cmd.act == ACT_SEND_HEAD))
        |=> (result_reg.send_valid && result_reg.in_flight && awaiting_reg))
        else $error("sent indication not marked in flight");

    // nothing is sent while an indication is in flight or the link is closed
    a_no_send_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && sending) |-> (!awaiting_reg && link_open_reg))
        else $error("indication issued while one is in flight");

endmodule
